// ===== rtl/bbc_pkg.sv =====
// Package for the bracket balance checker: sizes, codes and character classification.
`timescale 1ns / 1ps
package bbc_pkg;

	localparam int STACK_DEPTH    = 256;
	localparam int POSITION_WIDTH = 16;
	localparam int ADDR_W         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int COUNT_W        = $clog2(STACK_DEPTH + 1);
	localparam int OUT_POS_W      = 16;

	localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

	typedef logic [1:0]                kind_t;
	typedef logic [POSITION_WIDTH-1:0] pos_t;
	typedef logic [COUNT_W-1:0]        count_t;
	typedef logic [ADDR_W-1:0]         addr_t;

	localparam kind_t KIND_BRACE   = 2'd0;
	localparam kind_t KIND_PAREN   = 2'd1;
	localparam kind_t KIND_BRACKET = 2'd2;
	localparam kind_t KIND_NONE    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CLOSE    = 2'd1;
	localparam logic [1:0] ST_OPEN     = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
	localparam logic [7:0] CH_OPEN_PAREN    = 8'h28;
	localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
	localparam logic [7:0] CH_CLOSE_PAREN   = 8'h29;
	localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
	localparam logic [7:0] CH_NUL           = 8'h00;
	localparam logic [7:0] CH_NEWLINE       = 8'h0A;

	function automatic kind_t open_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_OPEN_BRACE:   k = KIND_BRACE;
			CH_OPEN_PAREN:   k = KIND_PAREN;
			CH_OPEN_BRACKET: k = KIND_BRACKET;
			default:         k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t close_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_CLOSE_BRACE:   k = KIND_BRACE;
			CH_CLOSE_PAREN:   k = KIND_PAREN;
			CH_CLOSE_BRACKET: k = KIND_BRACKET;
			default:          k = KIND_NONE;
		endcase
		return k;
	endfunction

	// The reported position is the low sixteen bits of the internal position.
	function automatic logic [OUT_POS_W-1:0] out_pos(input pos_t p);
		logic [31:0] w;
		w = 32'(p);
		return w[OUT_POS_W-1:0];
	endfunction

endpackage

// ===== rtl/bbc_stack_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port, used for the bracket stack.
`timescale 1ns / 1ps
module bbc_stack_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 2
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// Top level of the bracket balance checker: stack control, position counter and result register.
// Results are registered: a result appears on the outputs in the cycle after the transaction that causes it.
// Throughput: one character per cycle while in_stall is low; the top kind sits in a register
// and the RAM is read every cycle at the entry below it, so a pop has its new top ready in time.
// Reset clears the stack count, position, skip flag and output valid; the stack RAM is not
// cleared, as only entries below the count are ever used.
`timescale 1ns / 1ps
module bracket_balance_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] error_position
);
	import bbc_pkg::*;

	count_t count_q, count_d;
	pos_t   pos_q, pos_d, pos_inc;
	logic   skip_q, skip_d;
	kind_t  top_kind_q, top_kind_d;
	pos_t   bottom_pos_q, bottom_pos_d;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] err_pos_q;

	logic        accept, is_term, emit;
	logic [1:0]  emit_status;
	logic [15:0] emit_pos;
	kind_t       ok, ck, rd_kind;
	logic        we;
	addr_t       raddr;
	count_t      below_cnt;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign is_term  = (char_code == CH_NUL) || (char_code == CH_NEWLINE);
	assign ok       = open_kind(char_code);
	assign ck       = close_kind(char_code);
	assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + pos_t'(1);

	always_comb begin
		count_d      = count_q;
		pos_d        = pos_q;
		skip_d       = skip_q;
		top_kind_d   = top_kind_q;
		bottom_pos_d = bottom_pos_q;
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_pos     = '0;
		we           = 1'b0;
		if (accept) begin
			if (is_term) begin
				if (!skip_q) begin
					emit = 1'b1;
					if (count_q == '0) begin
						emit_status = ST_OK;
						emit_pos    = '0;
					end else begin
						emit_status = ST_OPEN;
						emit_pos    = out_pos(bottom_pos_q);
					end
				end
				count_d = '0;
				pos_d   = '0;
				skip_d  = 1'b0;
			end else if (!skip_q) begin
				pos_d = pos_inc;
				if (ok != KIND_NONE) begin
					if (count_q == COUNT_W'(STACK_DEPTH)) begin
						skip_d      = 1'b1;
						emit        = 1'b1;
						emit_status = ST_OVERFLOW;
						emit_pos    = out_pos(pos_inc);
					end else begin
						we         = 1'b1;
						count_d    = count_q + count_t'(1);
						top_kind_d = ok;
						if (count_q == '0) begin
							bottom_pos_d = pos_inc;
						end
					end
				end else if (ck != KIND_NONE) begin
					if (count_q == '0 || top_kind_q != ck) begin
						skip_d      = 1'b1;
						emit        = 1'b1;
						emit_status = ST_CLOSE;
						emit_pos    = out_pos(pos_inc);
					end else begin
						count_d    = count_q - count_t'(1);
						top_kind_d = rd_kind;
					end
				end
			end
		end
	end

	// The read always targets the entry just below the top that the next cycle will see.
	assign below_cnt = count_d - count_t'(2);
	assign raddr     = below_cnt[ADDR_W-1:0];

	bbc_stack_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH($bits(kind_t))
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(ok),
		.raddr(raddr),
		.rdata(rd_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			pos_q   <= pos_d;
			skip_q  <= skip_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_kind_q   <= top_kind_d;
		bottom_pos_q <= bottom_pos_d;
		if (emit) begin
			status_q  <= emit_status;
			err_pos_q <= emit_pos;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign error_position = err_pos_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_term |=> count_q == '0 && pos_q == '0 && !skip_q)
		else $error("terminator did not clear the state");

	a_error_skips: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (emit_status == ST_CLOSE || emit_status == ST_OVERFLOW) |=> skip_q)
		else $error("error report did not start skipping");

	a_no_emit_skip: assert property (@(posedge clk) disable iff (!arst_n)
		accept && skip_q && !is_term |=> $stable(count_q) && $stable(pos_q))
		else $error("state changed while skipping");

endmodule

// ===== tb/tb_bracket_balance_checker.sv =====
// Self-checking testbench for the bracket balance checker, with a scoreboard class and random traffic.
`timescale 1ns / 1ps
module tb_bracket_balance_checker;
	import bbc_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 480;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 20;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] position;
	} report_t;

	// Tracks the bracket stack alongside the block and holds the reports it should produce.
	class bracket_scoreboard;
		kind_t       kinds [STACK_DEPTH];
		pos_t        posns [STACK_DEPTH];
		int unsigned depth;
		pos_t        position;
		bit          skipping;
		report_t     expected_reports [$];
		int          errors;

		function new();
			depth    = 0;
			position = '0;
			skipping = 1'b0;
			errors   = 0;
		endfunction

		function kind_t opener_kind(logic [7:0] c);
			case (c)
				CH_OPEN_BRACE:   return KIND_BRACE;
				CH_OPEN_PAREN:   return KIND_PAREN;
				CH_OPEN_BRACKET: return KIND_BRACKET;
				default:         return KIND_NONE;
			endcase
		endfunction

		function kind_t closer_kind(logic [7:0] c);
			case (c)
				CH_CLOSE_BRACE:   return KIND_BRACE;
				CH_CLOSE_PAREN:   return KIND_PAREN;
				CH_CLOSE_BRACKET: return KIND_BRACKET;
				default:          return KIND_NONE;
			endcase
		endfunction

		function void add_report(logic [1:0] st, pos_t p);
			report_t r;
			logic [31:0] wide;
			wide       = 32'(p);
			r.status   = st;
			r.position = wide[15:0];
			expected_reports.push_back(r);
		endfunction

		function void note_char(logic [7:0] c);
			kind_t ok;
			kind_t ck;
			if (c == CH_NUL || c == CH_NEWLINE) begin
				if (!skipping) begin
					if (depth == 0)
						add_report(ST_OK, '0);
					else
						add_report(ST_OPEN, posns[0]);
				end
				depth    = 0;
				position = '0;
				skipping = 1'b0;
				return;
			end
			if (skipping)
				return;
			if (position != POS_MAX)
				position = position + 1'b1;
			ok = opener_kind(c);
			ck = closer_kind(c);
			if (ok != KIND_NONE) begin
				if (depth >= STACK_DEPTH) begin
					skipping = 1'b1;
					add_report(ST_OVERFLOW, position);
				end else begin
					kinds[depth] = ok;
					posns[depth] = position;
					depth++;
				end
			end else if (ck != KIND_NONE) begin
				if (depth == 0 || kinds[depth-1] != ck) begin
					skipping = 1'b1;
					add_report(ST_CLOSE, position);
				end else begin
					depth--;
				end
			end
		endfunction

		function void check_result(logic [1:0] st, logic [15:0] ep);
			report_t r;
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d position %0d",
					$time, st, ep);
				return;
			end
			r = expected_reports.pop_front();
			if (st !== r.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, st);
			end
			if (ep !== r.position) begin
				errors++;
				$display("%0t: error_position mismatch, expected %0d, actual %0d",
					$time, r.position, ep);
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] error_position;

	bracket_scoreboard sb;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          hold_req;
	int          items_sent;
	int          cycle_count;
	logic [7:0]  line_buf [$];

	bracket_balance_checker DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.error_position (error_position)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver stalls at random, and holds off for a long stretch when asked.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, error_position);
	end

	function automatic logic [7:0] opener_char(int k);
		case (k)
			0:       return CH_OPEN_BRACE;
			1:       return CH_OPEN_PAREN;
			default: return CH_OPEN_BRACKET;
		endcase
	endfunction

	function automatic logic [7:0] closer_char(int k);
		case (k)
			0:       return CH_CLOSE_BRACE;
			1:       return CH_CLOSE_PAREN;
			default: return CH_CLOSE_BRACKET;
		endcase
	endfunction

	function automatic logic [7:0] filler();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (c == CH_NEWLINE || sb.opener_kind(c) != KIND_NONE ||
			sb.closer_kind(c) != KIND_NONE);
		return c;
	endfunction

	function automatic logic [7:0] terminator();
		return $urandom_range(0, 1) ? CH_NUL : CH_NEWLINE;
	endfunction

	// One transaction on the input channel, with an optional gap before it.
	task automatic send_char(input logic [7:0] c);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		sb.note_char(c);
		items_sent++;
	endtask

	task automatic send_line();
		while (line_buf.size() > 0)
			send_char(line_buf.pop_front());
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic send_random_line();
		int nest [$];
		int mode;
		int len;
		int k;
		int r;
		mode = $urandom_range(0, 99);
		len  = $urandom_range(1, 40);
		if (mode < 3) begin
			// Deep nesting right up to, and sometimes past, the stack depth.
			len = $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 2);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					line_buf.push_back(filler());
				k = $urandom_range(0, 2);
				nest.push_back(k);
				line_buf.push_back(opener_char(k));
			end
			while (nest.size() > 0 && $urandom_range(0, 31) != 0)
				line_buf.push_back(closer_char(nest.pop_back()));
		end else if (mode < 13) begin
			for (int i = 0; i < len; i++)
				line_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (mode >= 73 && mode < 82) begin
				k = $urandom_range(0, 2);
				nest.push_back(k);
				line_buf.push_back(opener_char(k));
			end
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 2);
				if (r == 0) begin
					k = $urandom_range(0, 2);
					nest.push_back(k);
					line_buf.push_back(opener_char(k));
				end else if (r == 1 && nest.size() > 0) begin
					line_buf.push_back(closer_char(nest.pop_back()));
				end else begin
					line_buf.push_back(filler());
				end
			end
			if (mode >= 60 && mode < 67) begin
				// Closing bracket of the wrong kind, or one with nothing open.
				if (nest.size() > 0)
					line_buf.push_back(closer_char((nest[$] + $urandom_range(1, 2)) % 3));
				else
					line_buf.push_back(closer_char($urandom_range(0, 2)));
			end else if (mode >= 67 && mode < 73) begin
				while (nest.size() > 0)
					line_buf.push_back(closer_char(nest.pop_back()));
				line_buf.push_back(closer_char($urandom_range(0, 2)));
			end else if (mode < 73 || mode >= 82) begin
				while (nest.size() > 0)
					line_buf.push_back(closer_char(nest.pop_back()));
			end
			// Trailing characters, dropped if an error has already been reported.
			if (mode >= 60 && mode < 73) begin
				repeat ($urandom_range(0, 4)) begin
					r = $urandom_range(0, 2);
					line_buf.push_back(r == 0 ? opener_char($urandom_range(0, 2)) :
						r == 1 ? closer_char($urandom_range(0, 2)) : filler());
				end
			end
		end
		line_buf.push_back(terminator());
		send_line();
	endtask

	task automatic run_random(input int goal);
		while (items_sent < goal)
			send_random_line();
	endtask

	initial begin
		int goal;
		sb          = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_code   = 8'h00;
		hold_req    = 1'b0;
		items_sent  = 0;
		cycle_count = 0;
		tx_idle_pct = 34;
		rx_idle_pct = 67;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: empty, matched, mismatched, unclosed and extreme bytes.
		line_buf.push_back(CH_NEWLINE);
		line_buf.push_back(CH_NUL);
		push_text("{[()]}");
		line_buf.push_back(CH_NUL);
		push_text(")");
		line_buf.push_back(CH_NEWLINE);
		push_text("[}x(");
		line_buf.push_back(CH_NEWLINE);
		push_text("{a");
		line_buf.push_back(CH_NEWLINE);
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		push_text("a(b[");
		line_buf.push_back(CH_NUL);
		send_line();

		// A full stack that is then emptied, and one that is left open.
		for (int i = 0; i < STACK_DEPTH; i++)
			line_buf.push_back(opener_char(i % 3));
		for (int i = STACK_DEPTH - 1; i >= 0; i--)
			line_buf.push_back(closer_char(i % 3));
		line_buf.push_back(CH_NEWLINE);
		for (int i = 0; i < STACK_DEPTH; i++)
			line_buf.push_back(opener_char(i % 3));
		line_buf.push_back(CH_NUL);
		// Overflow: one opening bracket beyond a full stack.
		for (int i = 0; i <= STACK_DEPTH; i++)
			line_buf.push_back(opener_char((i * 7) % 3));
		push_text(")]}");
		line_buf.push_back(CH_NEWLINE);
		send_line();

		goal = items_sent + RANDOM_ITEMS / 3;
		run_random(goal);

		// The receiver holds off while short, result-heavy strings keep arriving.
		hold_req = 1'b1;
		repeat (40) begin
			if ($urandom_range(0, 1))
				line_buf.push_back(terminator());
			else begin
				line_buf.push_back(closer_char($urandom_range(0, 2)));
				line_buf.push_back(terminator());
			end
			send_line();
		end

		tx_idle_pct = 67;
		rx_idle_pct = 34;
		goal = items_sent + RANDOM_ITEMS / 3;
		run_random(goal);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		goal = items_sent + RANDOM_ITEMS / 3;
		run_random(goal);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: expected %0d more results, actual none", $time, sb.pending());
		end
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bbc_pkg.sv
rtl/bbc_stack_ram.sv
rtl/bracket_balance_checker.sv
tb/tb_bracket_balance_checker.sv
